### rtl/core/bitmap_block_allocator_macros.svh
// Assertion macros used by the checker file bba_checker.sv.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BBA_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BBA_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

### rtl/core/bba_pkg.sv
package bba_pkg;

	localparam int NUM_BLOCKS    = 256;
	localparam int MAP_DEPTH     = 256;
	localparam int ACTIVE_BLOCKS = (NUM_BLOCKS < MAP_DEPTH) ? NUM_BLOCKS : MAP_DEPTH;

	localparam int IDX_W     = 8;
	localparam int WORD_W    = 32;
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int NUM_WORDS = MAP_DEPTH / WORD_W;
	localparam int WADDR_W   = $clog2(NUM_WORDS);
	localparam int LAST_WORD = (ACTIVE_BLOCKS - 1) / WORD_W;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_NONE_FREE    = 2'd1;
	localparam logic [1:0] ST_ALREADY_FREE = 2'd2;

	typedef struct packed {
		logic             func;
		logic [IDX_W-1:0] block_index;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] result_index;
	} rsp_t;

	// Bits of word w that belong to managed blocks.
	function automatic logic [WORD_W-1:0] word_mask(input logic [WADDR_W-1:0] w);
		logic [WORD_W-1:0] m;
		logic [IDX_W-1:0]  pos;
		m = '0;
		for (int b = 0; b < WORD_W; b++) begin
			pos  = {w, BIT_W'(b)};
			m[b] = (int'(pos) < ACTIVE_BLOCKS);
		end
		return m;
	endfunction

	// Binary position of the single set bit.
	function automatic logic [BIT_W-1:0] onehot_enc(input logic [WORD_W-1:0] oh);
		logic [BIT_W-1:0] enc;
		enc = '0;
		for (int b = 0; b < WORD_W; b++) begin
			if (oh[b]) begin
				enc = enc | BIT_W'(b);
			end
		end
		return enc;
	endfunction

endpackage

### rtl/core/bitmap_block_allocator.sv
// First-fit bitmap block allocator: one used bit per block, all free after reset. An allocate
// request returns the lowest free block and marks it used, or status 1 with index 0 when none
// is free; a free request clears the named block's bit and echoes its index, or answers status 2
// when the block was already free or is beyond the managed range. The bitmap is held as 32-bit
// words and one find-first-zero unit looks at one word per cycle, waiting on the deciding word
// while the output register is held; an allocate stops at the first word with a free block (8
// words for 256 blocks) and a free reads only the named block's word. One request is in flight
// at a time: req_stall is high from acceptance until the result enters the output register, which
// then holds it while rsp_stall is high and leaves the block free to take the next request.
module bitmap_block_allocator import bba_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FREE = 3'b100
	} state_t;

	localparam logic [WADDR_W-1:0] LAST_PTR = WADDR_W'(LAST_WORD);

	state_t              state_q;
	logic [WORD_W-1:0]   map_q [NUM_WORDS];
	logic [WADDR_W-1:0]  ptr_q;
	logic [IDX_W-1:0]    idx_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic                req_acc;
	logic                can_load;
	logic                done;
	logic [WADDR_W-1:0]  wsel;
	logic [WORD_W-1:0]   word;
	logic [WORD_W-1:0]   avail;
	logic [WORD_W-1:0]   first_oh;
	logic [BIT_W-1:0]    first_bit;
	logic                found;
	logic [WORD_W-1:0]   free_oh;
	logic                free_hit;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign can_load  = !rsp_valid_q || !rsp_stall;

	// Result ready to enter the output register this cycle.
	assign done      = can_load && ((state_q == S_FREE) ||
		((state_q == S_SCAN) && (found || ptr_q == LAST_PTR)));

	// Shared word read: scan pointer while searching, request word while freeing.
	assign wsel      = (state_q == S_FREE) ? idx_q[IDX_W-1:BIT_W] : ptr_q;
	assign word      = map_q[wsel];
	assign avail     = ~word & word_mask(wsel);
	assign first_oh  = avail & (~avail + WORD_W'(1));
	assign first_bit = onehot_enc(first_oh);
	assign found     = (avail != '0);
	assign free_oh   = WORD_W'(1) << idx_q[BIT_W-1:0];
	assign free_hit  = (int'(idx_q) < ACTIVE_BLOCKS) && ((word & free_oh) != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ptr_q       <= '0;
			rsp_valid_q <= 1'b0;
			for (int w = 0; w < NUM_WORDS; w++) begin
				map_q[w] <= '0;
			end
		end else begin
			// Load a new result, or hold a stalled one.
			rsp_valid_q <= done || (rsp_valid_q && rsp_stall);
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						ptr_q   <= '0;
						state_q <= (req.func == FUNC_FREE) ? S_FREE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (found) begin
						if (can_load) begin
							map_q[wsel] <= word | first_oh;
							state_q     <= S_IDLE;
						end
					end else if (ptr_q == LAST_PTR) begin
						if (can_load) begin
							state_q <= S_IDLE;
						end
					end else begin
						ptr_q <= ptr_q + WADDR_W'(1);
					end
				end
				S_FREE: begin
					if (can_load) begin
						if (free_hit) begin
							map_q[wsel] <= word & ~free_oh;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload; loaded only together with rsp_valid_q.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			idx_q <= req.block_index;
		end
		if (can_load) begin
			if (state_q == S_SCAN && found) begin
				rsp_q.status       <= ST_OK;
				rsp_q.result_index <= {ptr_q, first_bit};
			end else if (state_q == S_SCAN && ptr_q == LAST_PTR) begin
				rsp_q.status       <= ST_NONE_FREE;
				rsp_q.result_index <= '0;
			end else if (state_q == S_FREE) begin
				rsp_q.status       <= free_hit ? ST_OK : ST_ALREADY_FREE;
				rsp_q.result_index <= idx_q;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/core/bba_checker.sv
`include "bitmap_block_allocator_macros.svh"

module bba_checker import bba_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// Hold a stalled result transaction.
	`BBA_ASSERT_NEXT(a_rsp_hold_valid, rsp_valid && rsp_stall, rsp_valid)
	`BBA_ASSERT_NEXT(a_rsp_hold_data, rsp_valid && rsp_stall, $stable(rsp))
	// One request in flight: busy right after a request transaction.
	`BBA_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)
	// A failed allocate reports block zero.
	`BBA_ASSERT_NOW(a_none_free_idx, rsp_valid && rsp.status == ST_NONE_FREE, rsp.result_index == '0)
	// Only defined status codes.
	`BBA_ASSERT_NOW(a_status_code, rsp_valid, rsp.status == ST_OK || rsp.status == ST_NONE_FREE || rsp.status == ST_ALREADY_FREE)

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);

### tb/sv/bba_bitmap_checker.sv
module bba_bitmap_checker import bba_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   fail_count,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [MAP_DEPTH-1:0] used_bits;
	rsp_t                 answer_q[$];
	rsp_t                 oldest;
	int                   errors;

	// First-fit search on allocate, clear on free; updates used_bits.
	function automatic rsp_t apply_request(input req_t r);
		rsp_t a;
		bit   hit;
		a.status       = ST_NONE_FREE;
		a.result_index = '0;
		hit            = 1'b0;
		if (r.func == FUNC_ALLOC) begin
			for (int n = 0; n < ACTIVE_BLOCKS; n++) begin
				if (!hit && !used_bits[n]) begin
					hit            = 1'b1;
					used_bits[n]   = 1'b1;
					a.status       = ST_OK;
					a.result_index = IDX_W'(n);
				end
			end
		end else begin
			a.result_index = r.block_index;
			if (int'(r.block_index) < ACTIVE_BLOCKS && used_bits[r.block_index]) begin
				used_bits[r.block_index] = 1'b0;
				a.status                 = ST_OK;
			end else begin
				a.status = ST_ALREADY_FREE;
			end
		end
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answer_q.delete();
			used_bits = '0;
			errors = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			// Retire the response first: it can never belong to a request taken this edge.
			if (rsp_valid && !rsp_stall) begin
				if (answer_q.size() == 0) begin
					errors++;
					$error("response with no request waiting: status %0d, result_index %0d",
						rsp.status, rsp.result_index);
				end else begin
					oldest = answer_q.pop_front();
					if (rsp.status !== oldest.status) begin
						errors++;
						$error("status: expected %0d, actual %0d", oldest.status, rsp.status);
					end
					if (rsp.result_index !== oldest.result_index) begin
						errors++;
						$error("result_index: expected %0d, actual %0d",
							oldest.result_index, rsp.result_index);
					end
				end
			end
			if (req_valid && !req_stall) begin
				answer_q.push_back(apply_request(req));
			end
			fail_count <= errors;
			outstanding <= answer_q.size();
		end
	end

endmodule

### tb/sv/tb_top.sv
module tb_top;
	import bba_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	int   mismatches;
	int   outstanding;

	int   send_pct;
	int   stall_pct;
	int   live;
	bit   hold_request;
	int   hold_left;

	bitmap_block_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	bba_bitmap_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.fail_count  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
	end

	always #1 clk = ~clk;

	// Offer one transaction, optionally after an idle gap, and hold it until taken.
	task automatic issue(input logic f, input logic [IDX_W-1:0] idx);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_pct) begin
			gap++;
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.func <= f;
		req.block_index <= idx;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		if (f == FUNC_ALLOC) begin
			if (live < ACTIVE_BLOCKS) begin
				live++;
			end
		end else if (int'(idx) < live && live > 0) begin
			live--;
		end
	endtask

	// Stop offering and wait until every expected result has come.
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic random_phase(input int count, input int alloc_pct, input int hold_at);
		logic [IDX_W-1:0] idx;
		for (int i = 0; i < count; i++) begin
			if (i == hold_at) begin
				hold_request = 1'b1;
			end
			if ($urandom_range(99) < alloc_pct) begin
				issue(FUNC_ALLOC, IDX_W'($urandom_range(255)));
			end else begin
				// Mostly target the packed low region, where blocks are likely in use.
				if (live > 0 && $urandom_range(99) < 70) begin
					idx = IDX_W'($urandom_range(live - 1));
				end else begin
					idx = IDX_W'($urandom_range(255));
				end
				issue(FUNC_FREE, idx);
			end
		end
	endtask

	// Receiver: random stalls, plus a long hold-off when asked.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left = 0;
		end else if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left--;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 299;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		send_pct = 0;
		stall_pct = 0;
		live = 0;
		hold_request = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: holes, double free, high indices and ignored index bits.
		issue(FUNC_ALLOC, 8'h00);
		issue(FUNC_ALLOC, 8'h00);
		issue(FUNC_ALLOC, 8'h00);
		issue(FUNC_FREE, 8'h01);
		issue(FUNC_ALLOC, 8'h55);
		issue(FUNC_FREE, 8'h03);
		issue(FUNC_FREE, 8'hFF);
		issue(FUNC_FREE, 8'h00);
		issue(FUNC_FREE, 8'h00);
		issue(FUNC_ALLOC, 8'hFF);
		issue(FUNC_FREE, 8'h80);
		issue(FUNC_FREE, 8'h02);
		issue(FUNC_FREE, 8'h01);
		issue(FUNC_FREE, 8'h00);
		issue(FUNC_FREE, 8'h00);
		issue(FUNC_ALLOC, 8'hAA);
		issue(FUNC_FREE, 8'h00);
		drain();
		live = 0;

		// No idling; fill past full, with one long receiver hold-off.
		send_pct = 0;
		stall_pct = 0;
		random_phase(400, 90, 60);
		drain();

		// Sender mostly idle; free-heavy.
		send_pct = 74;
		stall_pct = 0;
		random_phase(350, 25, -1);
		drain();

		// Receiver mostly stalling; refill.
		send_pct = 0;
		stall_pct = 74;
		random_phase(400, 85, 200);
		drain();

		// Both idle a little; mixed traffic.
		send_pct = 17;
		stall_pct = 17;
		random_phase(350, 50, -1);

		@(posedge clk);
		req_valid <= 1'b0;
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/bba_pkg.sv
rtl/core/bitmap_block_allocator.sv
rtl/core/bba_checker.sv
tb/sv/bba_bitmap_checker.sv
tb/sv/tb_top.sv
